### hdl/rtch_pkg.sv
// Shared types, constants and a saturation helper function of the ray/triangle closest-hit block.
package rtch_pkg;

    // Widths of the internal arithmetic.
    localparam int VW = 33;   // vertex differences and negated direction
    localparam int MW = 34;   // multiplier operand
    localparam int PW = 68;   // multiplier product
    localparam int CW = 67;   // cross product component
    localparam int DW = 104;  // determinants and their accumulator
    localparam int QW = 31;   // saturated quotient
    localparam int LO_SPLIT = 33;  // cross component split point for the dot product

    localparam int QDEPTH = 2;

    typedef enum logic [0:0] {
        OP_RAY = 1'b0,
        OP_TRI = 1'b1
    } t_op;

    localparam logic CFG_MIN_DIST = 1'b0;
    localparam logic CFG_MAX_DIST = 1'b1;

    localparam logic [QW-1:0] MIN_DIST_RST = 31'd655;
    localparam logic [QW-1:0] MAX_DIST_RST = 31'h7FFF_FFFF;

    typedef struct packed {
        t_op                opcode;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
        logic signed [31:0] c_x;
        logic signed [31:0] c_y;
        logic signed [31:0] c_z;
        logic               last_triangle;
    } t_in_item;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic signed [31:0] hit_distance;
        logic [15:0]        hit_index;
    } t_out_item;

    typedef struct packed {
        logic [QW-1:0] min_dist;
        logic [QW-1:0] max_dist;
    } t_cfg;

    typedef struct packed {
        logic     valid;
        logic     is_tri;
        logic     last;
        t_in_item item;
    } t_work;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] num;
        logic [DW-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [QW-1:0] quot;
    } t_div_rsp;

    function automatic logic signed [31:0] sat32(input logic signed [35:0] x);
        logic signed [35:0] s_max;
        logic signed [35:0] s_min;
        s_max = 36'sd2147483647;
        s_min = -36'sd2147483648;
        if (x > s_max) begin
            return 32'sh7FFF_FFFF;
        end else if (x < s_min) begin
            return 32'sh8000_0000;
        end
        return 32'(x);
    endfunction

endpackage

### hdl/rtch_front.sv
// Front end: request queue that takes items and classifies them for the engine.
module rtch_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  rtch_pkg::t_in_item i_item,
    output rtch_pkg::t_work   o_work,
    input  logic              i_pop
);
    import rtch_pkg::*;

    localparam int PTRW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

    t_in_item          r_mem [QDEPTH];
    logic [PTRW-1:0]   r_wr;
    logic [PTRW-1:0]   r_rd;
    logic [PTRW:0]     r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_stall = (r_cnt == (PTRW+1)'(QDEPTH));
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = i_pop && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == PTRW'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= (r_rd == PTRW'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_comb begin
        o_work.valid  = (r_cnt != '0);
        o_work.item   = r_mem[r_rd];
        o_work.is_tri = (r_mem[r_rd].opcode == OP_TRI);
        o_work.last   = r_mem[r_rd].last_triangle;
    end

endmodule

### hdl/rtch_div.sv
// Radix-2 restoring divider giving floor(num * 2^FRAC_BITS / den), saturated to 31 bits.
module rtch_div #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  rtch_pkg::t_div_req i_req,
    output rtch_pkg::t_div_rsp o_rsp
);
    import rtch_pkg::*;

    localparam int SH = QW - FRAC_BITS;
    localparam logic [4:0] NSTEP = 5'(QW);

    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [QW-1:0] r_low;
    logic [QW-1:0] r_q;
    logic [4:0]    r_cnt;
    logic          r_busy;
    logic          r_done;

    logic [DW-1:0] w_top;
    logic          w_sat;
    logic [QW-1:0] w_low_init;
    logic [DW:0]   w_trial;
    logic          w_ge;

    // The upper quotient bits are all zero exactly when num >> SH is below den.
    assign w_top      = i_req.num >> SH;
    assign w_sat      = (w_top >= i_req.den);
    assign w_low_init = i_req.num[QW-1:0] << FRAC_BITS;
    assign w_trial    = {r_rem, r_low[QW-1]};
    assign w_ge       = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_den <= i_req.den;
                if (w_sat) begin
                    r_q    <= MAX_DIST_RST;
                    r_done <= 1'b1;
                end else begin
                    r_rem  <= w_top;
                    r_low  <= w_low_init;
                    r_q    <= '0;
                    r_cnt  <= NSTEP;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= w_ge ? DW'(w_trial - {1'b0, r_den}) : DW'(w_trial);
                r_q   <= {r_q[QW-2:0], w_ge};
                r_low <= {r_low[QW-2:0], 1'b0};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

### hdl/rtch_back.sv
// Back end: determinant sequencer on one shared multiplier, hit test and nearest-hit tracking.
module rtch_back #(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_TRIANGLES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rtch_pkg::t_work     i_work,
    output logic                o_work_pop,
    input  rtch_pkg::t_cfg      i_cfg,
    output logic                o_res_valid,
    output rtch_pkg::t_out_item o_res,
    input  logic                i_res_take
);
    import rtch_pkg::*;

    localparam int UW = FRAC_BITS + 1;
    localparam logic [15:0] CNT_LAST = 16'(MAX_TRIANGLES - 1);

    localparam logic [1:0] TS_DET = 2'd0;
    localparam logic [1:0] TS_NT  = 2'd1;
    localparam logic [1:0] TS_NU  = 2'd2;
    localparam logic [1:0] TS_NV  = 2'd3;

    typedef enum logic [11:0] {
        S_IDLE   = 12'b0000_0000_0001,
        S_TRIPLE = 12'b0000_0000_0010,
        S_STORE  = 12'b0000_0000_0100,
        S_NORM   = 12'b0000_0000_1000,
        S_CHECK  = 12'b0000_0001_0000,
        S_DIV_T  = 12'b0000_0010_0000,
        S_DIV_U  = 12'b0000_0100_0000,
        S_DIV_V  = 12'b0000_1000_0000,
        S_POINT  = 12'b0001_0000_0000,
        S_UPDATE = 12'b0010_0000_0000,
        S_COUNT  = 12'b0100_0000_0000,
        S_RESULT = 12'b1000_0000_0000
    } t_state;

    t_state r_state;
    logic [3:0] r_step;
    logic [1:0] r_tsel;
    logic       r_last;

    logic signed [31:0]   r_org [3];
    logic signed [VW-1:0] r_nd  [3];
    logic signed [31:0]   r_p0  [3];
    logic signed [VW-1:0] r_e0  [3];
    logic signed [VW-1:0] r_e1  [3];
    logic signed [VW-1:0] r_s   [3];

    logic signed [CW-1:0] r_cx;
    logic signed [CW-1:0] r_cy;
    logic signed [CW-1:0] r_cz;
    logic signed [DW-1:0] r_acc;
    logic signed [DW-1:0] r_det;
    logic signed [DW-1:0] r_nt;
    logic signed [DW-1:0] r_nu;
    logic signed [DW-1:0] r_nv;

    logic signed [PW-1:0] r_prod;
    logic                 r_pvld;
    logic [3:0]           r_pstep;
    logic                 r_ppt;
    logic signed [PW-1:0] r_off [3];

    logic [QW-1:0] r_tq;
    logic [UW-1:0] r_uq;
    logic [UW-1:0] r_vq;
    logic          r_div_start;

    logic [QW-1:0]      r_best_dist;
    logic signed [31:0] r_best_pt [3];
    logic [15:0]        r_best_idx;
    logic               r_any_hit;
    logic [15:0]        r_tri_cnt;

    logic signed [31:0]   w_a [3];
    logic signed [31:0]   w_b [3];
    logic signed [31:0]   w_c [3];
    logic signed [VW-1:0] w_va [3];
    logic signed [VW-1:0] w_vb [3];
    logic signed [VW-1:0] w_vc [3];
    logic signed [MW-1:0] w_ma;
    logic signed [MW-1:0] w_mb;
    logic signed [PW-1:0] w_prod;
    logic                 w_issue;
    logic [DW:0]          w_uvsum;
    t_div_req             w_div_req;
    t_div_rsp             w_div_rsp;

    assign w_a[0] = i_work.item.a_x;
    assign w_a[1] = i_work.item.a_y;
    assign w_a[2] = i_work.item.a_z;
    assign w_b[0] = i_work.item.b_x;
    assign w_b[1] = i_work.item.b_y;
    assign w_b[2] = i_work.item.b_z;
    assign w_c[0] = i_work.item.c_x;
    assign w_c[1] = i_work.item.c_y;
    assign w_c[2] = i_work.item.c_z;

    assign o_work_pop = (r_state == S_IDLE) && i_work.valid;

    // Vectors of the triple product a . (b x c) being evaluated.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            case (r_tsel)
                TS_DET: begin
                    w_va[k] = r_nd[k]; w_vb[k] = r_e0[k]; w_vc[k] = r_e1[k];
                end
                TS_NT: begin
                    w_va[k] = r_s[k];  w_vb[k] = r_e0[k]; w_vc[k] = r_e1[k];
                end
                TS_NU: begin
                    w_va[k] = r_nd[k]; w_vb[k] = r_s[k];  w_vc[k] = r_e1[k];
                end
                default: begin
                    w_va[k] = r_nd[k]; w_vb[k] = r_e0[k]; w_vc[k] = r_s[k];
                end
            endcase
        end
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        if (r_state == S_POINT) begin
            case (r_step)
                4'd0: begin w_ma = MW'($signed({1'b0, r_uq})); w_mb = MW'(r_e0[0]); end
                4'd1: begin w_ma = MW'($signed({1'b0, r_vq})); w_mb = MW'(r_e1[0]); end
                4'd2: begin w_ma = MW'($signed({1'b0, r_uq})); w_mb = MW'(r_e0[1]); end
                4'd3: begin w_ma = MW'($signed({1'b0, r_vq})); w_mb = MW'(r_e1[1]); end
                4'd4: begin w_ma = MW'($signed({1'b0, r_uq})); w_mb = MW'(r_e0[2]); end
                4'd5: begin w_ma = MW'($signed({1'b0, r_vq})); w_mb = MW'(r_e1[2]); end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end else begin
            case (r_step)
                4'd0:  begin w_ma = MW'(w_vb[1]); w_mb = MW'(w_vc[2]); end
                4'd1:  begin w_ma = MW'(w_vb[2]); w_mb = MW'(w_vc[1]); end
                4'd2:  begin w_ma = MW'(w_vb[2]); w_mb = MW'(w_vc[0]); end
                4'd3:  begin w_ma = MW'(w_vb[0]); w_mb = MW'(w_vc[2]); end
                4'd4:  begin w_ma = MW'(w_vb[0]); w_mb = MW'(w_vc[1]); end
                4'd5:  begin w_ma = MW'(w_vb[1]); w_mb = MW'(w_vc[0]); end
                4'd6:  begin w_ma = $signed({1'b0, r_cx[LO_SPLIT-1:0]}); w_mb = MW'(w_va[0]); end
                4'd7:  begin w_ma = $signed(r_cx[CW-1:LO_SPLIT]);       w_mb = MW'(w_va[0]); end
                4'd8:  begin w_ma = $signed({1'b0, r_cy[LO_SPLIT-1:0]}); w_mb = MW'(w_va[1]); end
                4'd9:  begin w_ma = $signed(r_cy[CW-1:LO_SPLIT]);       w_mb = MW'(w_va[1]); end
                4'd10: begin w_ma = $signed({1'b0, r_cz[LO_SPLIT-1:0]}); w_mb = MW'(w_va[2]); end
                4'd11: begin w_ma = $signed(r_cz[CW-1:LO_SPLIT]);       w_mb = MW'(w_va[2]); end
                default: begin w_ma = '0; w_mb = '0; end
            endcase
        end
    end

    assign w_prod  = w_ma * w_mb;
    assign w_issue = ((r_state == S_TRIPLE) && (r_step <= 4'd11)) ||
                     ((r_state == S_POINT) && (r_step <= 4'd5));
    assign w_uvsum = {1'b0, r_nu} + {1'b0, r_nv};

    // Product accumulation from the registered product, in the cycle after its issue.
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_pvld) begin
            if (r_ppt) begin
                case (r_pstep)
                    4'd0: r_off[0] <= r_prod;
                    4'd1: r_off[0] <= r_off[0] + r_prod;
                    4'd2: r_off[1] <= r_prod;
                    4'd3: r_off[1] <= r_off[1] + r_prod;
                    4'd4: r_off[2] <= r_prod;
                    4'd5: r_off[2] <= r_off[2] + r_prod;
                    default: r_off[0] <= r_off[0];
                endcase
            end else begin
                case (r_pstep)
                    4'd0: r_cx <= CW'(r_prod);
                    4'd1: r_cx <= r_cx - CW'(r_prod);
                    4'd2: r_cy <= CW'(r_prod);
                    4'd3: r_cy <= r_cy - CW'(r_prod);
                    4'd4: r_cz <= CW'(r_prod);
                    4'd5: r_cz <= r_cz - CW'(r_prod);
                    4'd6: r_acc <= DW'(r_prod);
                    4'd8, 4'd10: r_acc <= r_acc + DW'(r_prod);
                    4'd7, 4'd9, 4'd11: r_acc <= r_acc + (DW'(r_prod) <<< LO_SPLIT);
                    default: r_acc <= r_acc;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_tsel      <= TS_DET;
            r_pvld      <= 1'b0;
            r_div_start <= 1'b0;
            r_best_dist <= MAX_DIST_RST;
            r_best_idx  <= '0;
            r_any_hit   <= 1'b0;
            r_tri_cnt   <= '0;
            for (int k = 0; k < 3; k++) begin
                r_org[k] <= '0;
                r_nd[k]  <= '0;
            end
        end else begin
            r_pvld      <= w_issue;
            r_pstep     <= r_step;
            r_ppt       <= (r_state == S_POINT);
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_work.valid) begin
                        if (!i_work.is_tri) begin
                            for (int k = 0; k < 3; k++) begin
                                r_org[k] <= w_a[k];
                                r_nd[k]  <= -(VW'(w_b[k]));
                            end
                            r_best_dist <= i_cfg.max_dist;
                            r_best_idx  <= '0;
                            r_any_hit   <= 1'b0;
                            r_tri_cnt   <= '0;
                        end else begin
                            for (int k = 0; k < 3; k++) begin
                                r_p0[k] <= w_a[k];
                                r_e0[k] <= VW'(w_b[k]) - VW'(w_a[k]);
                                r_e1[k] <= VW'(w_c[k]) - VW'(w_a[k]);
                                r_s[k]  <= VW'(r_org[k]) - VW'(w_a[k]);
                            end
                            r_last  <= i_work.last;
                            r_tsel  <= TS_DET;
                            r_step  <= '0;
                            r_state <= S_TRIPLE;
                        end
                    end
                end
                S_TRIPLE: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd12) begin
                        r_state <= S_STORE;
                    end
                end
                S_STORE: begin
                    case (r_tsel)
                        TS_DET:  r_det <= r_acc;
                        TS_NT:   r_nt  <= r_acc;
                        TS_NU:   r_nu  <= r_acc;
                        default: r_nv  <= r_acc;
                    endcase
                    if ((r_tsel == TS_DET) && (r_acc == '0)) begin
                        r_state <= S_COUNT;
                    end else if (r_tsel == TS_NV) begin
                        r_state <= S_NORM;
                    end else begin
                        r_tsel  <= r_tsel + 1'b1;
                        r_step  <= '0;
                        r_state <= S_TRIPLE;
                    end
                end
                S_NORM: begin
                    if (r_det[DW-1]) begin
                        r_det <= -r_det;
                        r_nt  <= -r_nt;
                        r_nu  <= -r_nu;
                        r_nv  <= -r_nv;
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_nt[DW-1] || r_nu[DW-1] || r_nv[DW-1] ||
                        ({1'b0, r_det} < w_uvsum)) begin
                        r_state <= S_COUNT;
                    end else begin
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_T;
                    end
                end
                S_DIV_T: begin
                    if (w_div_rsp.done) begin
                        if ((w_div_rsp.quot <= i_cfg.min_dist) ||
                            (w_div_rsp.quot >= r_best_dist)) begin
                            r_state <= S_COUNT;
                        end else begin
                            r_tq        <= w_div_rsp.quot;
                            r_div_start <= 1'b1;
                            r_state     <= S_DIV_U;
                        end
                    end
                end
                S_DIV_U: begin
                    if (w_div_rsp.done) begin
                        r_uq        <= w_div_rsp.quot[UW-1:0];
                        r_div_start <= 1'b1;
                        r_state     <= S_DIV_V;
                    end
                end
                S_DIV_V: begin
                    if (w_div_rsp.done) begin
                        r_vq    <= w_div_rsp.quot[UW-1:0];
                        r_step  <= '0;
                        r_state <= S_POINT;
                    end
                end
                S_POINT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == 4'd6) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    for (int k = 0; k < 3; k++) begin
                        r_best_pt[k] <= sat32(36'(r_p0[k]) + 36'(r_off[k] >>> FRAC_BITS));
                    end
                    r_best_dist <= r_tq;
                    r_best_idx  <= r_tri_cnt;
                    r_any_hit   <= 1'b1;
                    r_state     <= S_COUNT;
                end
                S_COUNT: begin
                    r_tri_cnt <= (r_tri_cnt == CNT_LAST) ? '0 : r_tri_cnt + 1'b1;
                    r_state   <= r_last ? S_RESULT : S_IDLE;
                end
                S_RESULT: begin
                    if (i_res_take) begin
                        r_best_dist <= i_cfg.max_dist;
                        r_best_idx  <= '0;
                        r_any_hit   <= 1'b0;
                        r_tri_cnt   <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        w_div_req.start = r_div_start;
        w_div_req.den   = r_det;
        case (r_state)
            S_DIV_U: w_div_req.num = r_nu;
            S_DIV_V: w_div_req.num = r_nv;
            default: w_div_req.num = r_nt;
        endcase
    end

    rtch_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    assign o_res_valid        = (r_state == S_RESULT);
    assign o_res.hit          = r_any_hit;
    assign o_res.hit_x        = r_any_hit ? r_best_pt[0] : '0;
    assign o_res.hit_y        = r_any_hit ? r_best_pt[1] : '0;
    assign o_res.hit_z        = r_any_hit ? r_best_pt[2] : '0;
    assign o_res.hit_distance = r_any_hit ? $signed({1'b0, r_best_dist}) : '0;
    assign o_res.hit_index    = r_any_hit ? r_best_idx : '0;

    a_div_start_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_div_start |-> (r_state == S_DIV_T || r_state == S_DIV_U || r_state == S_DIV_V))
        else $error("divider started outside a division state");

    a_det_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV_T) |-> (!r_det[DW-1] && (r_det != '0)))
        else $error("division entered with a non-positive determinant");

    a_hit_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |-> ((r_tq > i_cfg.min_dist) && (r_tq < r_best_dist)))
        else $error("accepted hit lies outside the distance window");

endmodule

### hdl/ray_triangle_closest_hit.sv
// Top level of the ray versus triangle-list closest-hit engine.
//
// A begin-ray request loads the ray origin and direction and starts a new search; each
// following triangle request is tested exactly in signed fixed point (FRAC_BITS fraction
// bits) and the nearest accepted hit is kept. The triangle marked last produces one result
// (hit flag, point, distance t and triangle index, all zero on a miss) and starts a fresh
// search on the same ray. A triangle ends early when its system is singular or when it is
// rejected before the division; a hit runs through every step: the four 3x3 determinants
// go through one shared 34x34 multiplier at twelve products each, and t, u and v come out
// of one radix-2 divider at one quotient bit per cycle. A two-entry request queue sits in
// front of the engine and a result register after it, so the input side keeps taking
// requests, until the queue is full, while a result waits to be collected. Configuration
// writes are always taken; min_distance applies at once, max_distance when the next search
// starts, and both should only be changed while the block is idle.
module ray_triangle_closest_hit #(
    parameter int FRAC_BITS     = 16,
    parameter int MAX_TRIANGLES = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rtch_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rtch_pkg::t_out_item o_out_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [0:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data
);
    import rtch_pkg::*;

    t_cfg      r_cfg;
    t_work     w_work;
    logic      w_pop;
    logic      w_res_valid;
    t_out_item w_res;
    logic      w_res_take;
    logic      r_out_valid;
    t_out_item r_out_item;

    // Configuration registers: both are accepted in any cycle.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_dist <= MIN_DIST_RST;
            r_cfg.max_dist <= MAX_DIST_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_MIN_DIST: r_cfg.min_dist <= i_cfg_data[QW-1:0];
                CFG_MAX_DIST: r_cfg.max_dist <= i_cfg_data[QW-1:0];
                default:      r_cfg <= r_cfg;
            endcase
        end
    end

    rtch_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_item  (i_in_item),
        .o_work  (w_work),
        .i_pop   (w_pop)
    );

    rtch_back #(
        .FRAC_BITS     (FRAC_BITS),
        .MAX_TRIANGLES (MAX_TRIANGLES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_work      (w_work),
        .o_work_pop  (w_pop),
        .i_cfg       (r_cfg),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_take  (w_res_take)
    );

    // The result register takes a new result whenever it is empty or being emptied.
    assign w_res_take = w_res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_take) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule
